[src/mrmc_pkg.sv]
package mrmc_pkg;

   // number of relay outputs driven by the block
   localparam int NUM_OUTPUTS = 5;

   // per-output field widths inside the packed configuration registers
   localparam int MODE_W = 4;
   localparam int TIME_W = 11;
   localparam int SP_W   = 12;
   localparam int BAND_W = 8;
   localparam int THR_W  = 10;

   // register widths
   localparam int MODE_REG_W = NUM_OUTPUTS * MODE_W;
   localparam int TIME_REG_W = NUM_OUTPUTS * TIME_W;
   localparam int SP_REG_W   = NUM_OUTPUTS * SP_W;
   localparam int BAND_REG_W = NUM_OUTPUTS * BAND_W;
   localparam int THR_REG_W  = NUM_OUTPUTS * THR_W;

   // configuration bus
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_IDX_W  = 3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ON    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_OFF   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SP    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BAND  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_THR   = 3'd5;

   // opcodes
   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_SET_ONE = 2'd1;
   localparam logic [1:0] OP_TOGGLE  = 2'd2;
   localparam logic [1:0] OP_SET_ALL = 2'd3;

   // output mode codes
   localparam logic [MODE_W-1:0] MODE_MANUAL     = 4'd0;
   localparam logic [MODE_W-1:0] MODE_FORCE_ON   = 4'd1;
   localparam logic [MODE_W-1:0] MODE_FORCE_OFF  = 4'd2;
   localparam logic [MODE_W-1:0] MODE_TIMER      = 4'd3;
   localparam logic [MODE_W-1:0] MODE_T1_BELOW   = 4'd4;
   localparam logic [MODE_W-1:0] MODE_T1_ABOVE   = 4'd5;
   localparam logic [MODE_W-1:0] MODE_T2_BELOW   = 4'd6;
   localparam logic [MODE_W-1:0] MODE_T2_ABOVE   = 4'd7;
   localparam logic [MODE_W-1:0] MODE_L1_BELOW   = 4'd8;
   localparam logic [MODE_W-1:0] MODE_L1_ABOVE   = 4'd9;
   localparam logic [MODE_W-1:0] MODE_L2_BELOW   = 4'd10;
   localparam logic [MODE_W-1:0] MODE_L2_ABOVE   = 4'd11;

   // timer acts only during the first seconds of the matching minute
   localparam logic [5:0] TIMER_WINDOW = 6'd5;

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // configuration seen by the front
   typedef struct packed {
      logic [MODE_REG_W-1:0] mode_word;
      logic [TIME_REG_W-1:0] on_times;
      logic [TIME_REG_W-1:0] off_times;
      logic [SP_REG_W-1:0]   temp_setpoints;
      logic [BAND_REG_W-1:0] hysteresis_bands;
      logic [THR_REG_W-1:0]  light_thresholds;
   } cfg_type;

   // classified transaction: next = ((old & ~clr) | set) ^ tog
   typedef struct packed {
      logic [NUM_OUTPUTS-1:0] set;
      logic [NUM_OUTPUTS-1:0] clr;
      logic [NUM_OUTPUTS-1:0] tog;
   } action_type;

   // queue status
   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

[src/mrmc_csr.sv]
module mrmc_csr
   import mrmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type             cfg_ff;
   logic                wr_en;
   logic [CSR_IDX_W-1:0] idx;

   assign csr_pready = 1'b1;
   assign idx        = csr_paddr[CSR_ADDR_W-1 -: CSR_IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;

   // register writes, masked to each register width
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (wr_en) begin
         unique case (idx)
            REG_MODE: cfg_ff.mode_word        <= csr_pwdata[MODE_REG_W-1:0];
            REG_ON:   cfg_ff.on_times         <= csr_pwdata[TIME_REG_W-1:0];
            REG_OFF:  cfg_ff.off_times        <= csr_pwdata[TIME_REG_W-1:0];
            REG_SP:   cfg_ff.temp_setpoints   <= csr_pwdata[SP_REG_W-1:0];
            REG_BAND: cfg_ff.hysteresis_bands <= csr_pwdata[BAND_REG_W-1:0];
            REG_THR:  cfg_ff.light_thresholds <= csr_pwdata[THR_REG_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux, unknown index reads zero
   always_comb begin
      csr_prdata = '0;
      unique case (idx)
         REG_MODE: csr_prdata[MODE_REG_W-1:0] = cfg_ff.mode_word;
         REG_ON:   csr_prdata[TIME_REG_W-1:0] = cfg_ff.on_times;
         REG_OFF:  csr_prdata[TIME_REG_W-1:0] = cfg_ff.off_times;
         REG_SP:   csr_prdata[SP_REG_W-1:0]   = cfg_ff.temp_setpoints;
         REG_BAND: csr_prdata[BAND_REG_W-1:0] = cfg_ff.hysteresis_bands;
         REG_THR:  csr_prdata[THR_REG_W-1:0]  = cfg_ff.light_thresholds;
         default: ;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

[src/mrmc_front.sv]
module mrmc_front
   import mrmc_pkg::*;
(
   input  cfg_type                 cfg,
   input  logic [1:0]              opcode,
   input  logic [2:0]              channel,
   input  logic [NUM_OUTPUTS-1:0]  value,
   input  logic [4:0]              hour,
   input  logic [5:0]              minute,
   input  logic [5:0]              second,
   input  logic signed [11:0]      temp_one,
   input  logic signed [11:0]      temp_two,
   input  logic [9:0]              light_one,
   input  logic [9:0]              light_two,
   output action_type              action
);

   logic [NUM_OUTPUTS-1:0] ch_hit;
   logic [NUM_OUTPUTS-1:0] tick_set;
   logic [NUM_OUTPUTS-1:0] tick_clr;
   logic                   in_window;

   assign in_window = (second < TIMER_WINDOW);

   // channel decode, out-of-range channel selects nothing
   always_comb begin
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
         ch_hit[i] = (channel == 3'(i));
      end
   end

   // per-output evaluation for a control tick, all outputs in parallel
   always_comb begin
      logic [MODE_W-1:0]       mode;
      logic [TIME_W-1:0]       ton;
      logic [TIME_W-1:0]       toff;
      logic signed [SP_W+1:0]  sp;
      logic signed [SP_W+1:0]  band;
      logic signed [SP_W+1:0]  t1;
      logic signed [SP_W+1:0]  t2;
      logic signed [SP_W+1:0]  hi;
      logic signed [SP_W+1:0]  lo;
      logic [THR_W-1:0]        thr;
      logic                    on_hit;
      logic                    off_hit;
      t1 = 14'(temp_one);
      t2 = 14'(temp_two);
      for (int i = 0; i < NUM_OUTPUTS; i++) begin
         mode    = cfg.mode_word[i*MODE_W +: MODE_W];
         ton     = cfg.on_times[i*TIME_W +: TIME_W];
         toff    = cfg.off_times[i*TIME_W +: TIME_W];
         sp      = 14'(signed'(cfg.temp_setpoints[i*SP_W +: SP_W]));
         band    = 14'(cfg.hysteresis_bands[i*BAND_W +: BAND_W]);
         thr     = cfg.light_thresholds[i*THR_W +: THR_W];
         hi      = sp + band;
         lo      = sp - band;
         on_hit  = in_window && (ton[10:6] == hour) && (ton[5:0] == minute);
         off_hit = in_window && (toff[10:6] == hour) && (toff[5:0] == minute);
         tick_set[i] = 1'b0;
         tick_clr[i] = 1'b0;
         unique case (mode)
            MODE_FORCE_ON: begin
               tick_set[i] = 1'b1;
            end
            MODE_FORCE_OFF: begin
               tick_clr[i] = 1'b1;
            end
            MODE_TIMER: begin
               // off wins when both times match
               tick_clr[i] = off_hit;
               tick_set[i] = on_hit & ~off_hit;
            end
            MODE_T1_BELOW: begin
               tick_set[i] = (t1 <= sp);
               tick_clr[i] = ~(t1 <= sp) & (t1 >= hi);
            end
            MODE_T2_BELOW: begin
               tick_set[i] = (t2 <= sp);
               tick_clr[i] = ~(t2 <= sp) & (t2 >= hi);
            end
            MODE_T1_ABOVE: begin
               tick_set[i] = (t1 >= sp);
               tick_clr[i] = ~(t1 >= sp) & (t1 <= lo);
            end
            MODE_T2_ABOVE: begin
               tick_set[i] = (t2 >= sp);
               tick_clr[i] = ~(t2 >= sp) & (t2 <= lo);
            end
            MODE_L1_BELOW: begin
               tick_clr[i] = 1'b1;
               tick_set[i] = (light_one <= thr);
            end
            MODE_L1_ABOVE: begin
               tick_clr[i] = 1'b1;
               tick_set[i] = (light_one >= thr);
            end
            MODE_L2_BELOW: begin
               tick_clr[i] = 1'b1;
               tick_set[i] = (light_two <= thr);
            end
            MODE_L2_ABOVE: begin
               tick_clr[i] = 1'b1;
               tick_set[i] = (light_two >= thr);
            end
            default: ; // manual and unused codes hold
         endcase
      end
   end

   // classify the transaction into set/clear/toggle masks
   always_comb begin
      action = '0;
      unique case (opcode)
         OP_TICK: begin
            action.set = tick_set;
            action.clr = tick_clr;
         end
         OP_SET_ONE: begin
            action.clr = ch_hit;
            action.set = value[0] ? ch_hit : '0;
         end
         OP_TOGGLE: begin
            action.tog = ch_hit;
         end
         default: begin
            action.clr = '1;
            action.set = value;
         end
      endcase
   end

endmodule

[src/mrmc_queue.sv]
module mrmc_queue
   import mrmc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  action_type   push_data,
   input  logic         pop,
   output action_type   pop_data,
   output q_status_type status
);

   action_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_push;
   logic                do_pop;

   assign status.full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push & ~status.full;
   assign do_pop       = pop & ~status.empty;
   assign pop_data     = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // pointers wrap naturally, depth is a power of two
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[src/mrmc_back.sv]
module mrmc_back
   import mrmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  q_status_type           q_status,
   input  action_type             q_data,
   output logic                   q_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NUM_OUTPUTS-1:0] rsp_relay_vector,
   output logic                   rsp_changed
);

   logic [NUM_OUTPUTS-1:0] relay_ff;
   logic [NUM_OUTPUTS-1:0] relay_in;
   logic                   out_valid_ff;
   logic [NUM_OUTPUTS-1:0] out_vector_ff;
   logic                   out_changed_ff;

   // take the next transaction when the output register is free or draining
   assign q_pop    = ~q_status.empty & (~out_valid_ff | ~rsp_stall);
   assign relay_in = ((relay_ff & ~q_data.clr) | q_data.set) ^ q_data.tog;

   always_ff @(posedge clock) begin
      if (reset) begin
         relay_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else if (q_pop) begin
         relay_ff     <= relay_in;
         out_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (q_pop) begin
         out_vector_ff  <= relay_in;
         out_changed_ff <= (relay_in != relay_ff);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_relay_vector = out_vector_ff;
   assign rsp_changed      = out_changed_ff;

endmodule

[src/multi_output_relay_mode_controller.sv]
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  opcode, channel, value, time, sensors
// rsp       out        rsp_valid/rsp_stall  relay_vector, changed
// csr       in/out     APB, pready = 1      six registers at 8*i, 64-bit data
//
// One transaction per cycle sustained while rsp_stall is low; an accepted
// transaction passes the queue register, then the output register, before rsp_valid.
// The front classifies each transaction into set/clear/toggle masks in the
// accept cycle; the back applies them to the relay state as it pops them.
// Reset (synchronous) clears relay state, queue, output valid and configuration registers.
// A two-entry queue decouples the sides: req_stall rises only when it is full,
// and rsp_stall holds the output register while the queue keeps filling.
module multi_output_relay_mode_controller
   import mrmc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [1:0]             req_opcode,
   input  logic [2:0]             req_channel,
   input  logic [4:0]             req_value,
   input  logic [4:0]             req_hour,
   input  logic [5:0]             req_minute,
   input  logic [5:0]             req_second,
   input  logic signed [11:0]     req_temp_sensor_one,
   input  logic signed [11:0]     req_temp_sensor_two,
   input  logic [9:0]             req_light_sensor_one,
   input  logic [9:0]             req_light_sensor_two,
   // result channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [NUM_OUTPUTS-1:0] rsp_relay_vector,
   output logic                   rsp_changed,
   // configuration port
   input  logic                   csr_psel,
   input  logic                   csr_penable,
   input  logic                   csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_DATA_W-1:0]  csr_pwdata,
   output logic [CSR_DATA_W-1:0]  csr_prdata,
   output logic                   csr_pready
);

   cfg_type      cfg;
   action_type   front_action;
   action_type   q_data;
   q_status_type q_status;
   logic         q_pop;
   logic         req_accept;

   assign req_stall  = q_status.full;
   assign req_accept = req_valid & ~q_status.full;

   // configuration registers
   mrmc_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // classify incoming transaction
   mrmc_front u_front (
      .cfg       (cfg),
      .opcode    (req_opcode),
      .channel   (req_channel),
      .value     (req_value[NUM_OUTPUTS-1:0]),
      .hour      (req_hour),
      .minute    (req_minute),
      .second    (req_second),
      .temp_one  (req_temp_sensor_one),
      .temp_two  (req_temp_sensor_two),
      .light_one (req_light_sensor_one),
      .light_two (req_light_sensor_two),
      .action    (front_action)
   );

   // decoupling queue
   mrmc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (front_action),
      .pop       (q_pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   // apply to relay state and present the result
   mrmc_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .q_data           (q_data),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_relay_vector (rsp_relay_vector),
      .rsp_changed      (rsp_changed)
   );

endmodule
